FILE: design/hmt_pkg.sv
// Shared types and constants for the hotkey match table.
`default_nettype none

package hmt_pkg;

   // Transaction opcodes on the request channel
   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_KEY_DOWN = 2'd1,
      OP_KEY_UP   = 2'd2,
      OP_NOP      = 2'd3
   } opcode_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Modifier mask bit positions
   localparam int unsigned MASK_ALT   = 0;
   localparam int unsigned MASK_CTRL  = 1;
   localparam int unsigned MASK_SHIFT = 2;
   localparam int unsigned MASK_WIN   = 3;

   localparam int unsigned MODS_W  = 4;
   localparam int unsigned KEY_W   = 8;
   localparam int unsigned SLOT_W  = 4;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned ENTRY_W = MODS_W + KEY_W;

   // Virtual key codes
   localparam logic [KEY_W-1:0] KC_WIN_L   = 8'h5B;
   localparam logic [KEY_W-1:0] KC_WIN_R   = 8'h5C;
   localparam logic [KEY_W-1:0] KC_SHIFT_L = 8'hA0;
   localparam logic [KEY_W-1:0] KC_SHIFT_R = 8'hA1;
   localparam logic [KEY_W-1:0] KC_CTRL_L  = 8'hA2;
   localparam logic [KEY_W-1:0] KC_CTRL_R  = 8'hA3;
   localparam logic [KEY_W-1:0] KC_ALT_L   = 8'hA4;
   localparam logic [KEY_W-1:0] KC_ALT_R   = 8'hA5;

   // Register file
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic REG_ENTRY_COUNT = 1'b0;   // word index, paddr[2]

   // Controller to datapath commands
   typedef struct packed {
      logic capture;       // latch request fields, clear result
      logic load_write;    // write table slot
      logic scan_start;    // reset slot counter, read slot 0
      logic scan_step;     // evaluate current slot, advance
      logic result_load;   // move result to response register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      opcode_type opcode;
      logic       injected;
      logic       empty;     // no live slots
      logic       last;      // current slot is the last live one
      logic       hit;       // key-down match on current slot
      logic       out_free;  // response register can take a result
   } status_type;

endpackage

`default_nettype wire

FILE: design/hmt_ctrl.sv
// Controller state machine for the hotkey match table.
`default_nettype none

module hmt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire hmt_pkg::status_type status,
   output hmt_pkg::cmd_type        cmd
);

   hmt_pkg::state_type state_ff;
   hmt_pkg::state_type state_in;
   logic               scan_op;

   assign scan_op = ((status.opcode == hmt_pkg::OP_KEY_DOWN) ||
                     (status.opcode == hmt_pkg::OP_KEY_UP)) && !status.injected;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hmt_pkg::ST_IDLE: begin
            if (req_valid) state_in = hmt_pkg::ST_DECODE;
         end
         hmt_pkg::ST_DECODE: begin
            if (status.opcode != hmt_pkg::OP_LOAD && scan_op && !status.empty) begin
               state_in = hmt_pkg::ST_SCAN;
            end else begin
               state_in = hmt_pkg::ST_FINISH;
            end
         end
         hmt_pkg::ST_SCAN: begin
            if (status.last || status.hit) state_in = hmt_pkg::ST_FINISH;
         end
         hmt_pkg::ST_FINISH: begin
            if (status.out_free) state_in = hmt_pkg::ST_IDLE;
         end
         default: state_in = hmt_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         hmt_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         hmt_pkg::ST_DECODE: begin
            cmd.load_write = (status.opcode == hmt_pkg::OP_LOAD);
            cmd.scan_start = scan_op && !status.empty;
         end
         hmt_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         hmt_pkg::ST_FINISH: begin
            cmd.result_load = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/hmt_datapath.sv
// Datapath of the hotkey match table: slot memory, active flags, scan and result.
`default_nettype none

module hmt_datapath #(
   parameter int unsigned MAX_ENTRIES = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire hmt_pkg::cmd_type               cmd,
   output hmt_pkg::status_type                 status,
   input  wire logic [hmt_pkg::COUNT_W-1:0]    entry_count,
   input  wire logic [1:0]                     req_opcode,
   input  wire logic [hmt_pkg::SLOT_W-1:0]     req_entry_index,
   input  wire logic [hmt_pkg::MODS_W-1:0]     req_entry_mods,
   input  wire logic [hmt_pkg::KEY_W-1:0]      req_entry_key,
   input  wire logic [hmt_pkg::KEY_W-1:0]      req_key_code,
   input  wire logic [hmt_pkg::MODS_W-1:0]     req_modifiers_held,
   input  wire logic                           req_injected,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_fire,
   output logic [hmt_pkg::SLOT_W-1:0]          rsp_fire_index,
   output logic                                rsp_suppress
);

   localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned AW    = (IDX_W > hmt_pkg::SLOT_W) ? IDX_W : hmt_pkg::SLOT_W;
   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned LC_W  = (CNT_W > hmt_pkg::COUNT_W) ? CNT_W : hmt_pkg::COUNT_W;

   // Captured transaction
   hmt_pkg::opcode_type         opcode_ff;
   logic [hmt_pkg::SLOT_W-1:0]  eidx_ff;
   logic [hmt_pkg::MODS_W-1:0]  emods_ff;
   logic [hmt_pkg::KEY_W-1:0]   ekey_ff;
   logic [hmt_pkg::KEY_W-1:0]   key_ff;
   logic [hmt_pkg::MODS_W-1:0]  held_ff;
   logic                        injected_ff;

   // Scan state
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            rd_addr;
   logic [hmt_pkg::ENTRY_W-1:0] entry_mem [MAX_ENTRIES];
   logic [hmt_pkg::ENTRY_W-1:0] rd_data_ff;
   logic [MAX_ENTRIES-1:0]      active_ff, active_in;

   // Result accumulation and response register
   logic                        fire_ff, fire_in;
   logic [hmt_pkg::SLOT_W-1:0]  fidx_ff, fidx_in;
   logic                        supp_ff, supp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_fire_ff;
   logic [hmt_pkg::SLOT_W-1:0]  rsp_fidx_ff;
   logic                        rsp_supp_ff;

   // Derived values
   logic [LC_W-1:0]             count_w, max_w, live_n;
   logic [AW-1:0]               ld_wide, idx_wide;
   logic [IDX_W-1:0]            ld_addr;
   logic                        ld_in_range;
   logic [hmt_pkg::MODS_W-1:0]  cur_mods;
   logic [hmt_pkg::KEY_W-1:0]   cur_key;
   logic                        is_down, is_up, hit, up_clear, win_release;

   // Live slot count, clamped to the table size
   assign count_w = LC_W'(entry_count);
   assign max_w   = LC_W'(MAX_ENTRIES);
   assign live_n  = (count_w > max_w) ? max_w : count_w;

   assign ld_wide     = AW'(eidx_ff);
   assign ld_addr     = ld_wide[IDX_W-1:0];
   assign ld_in_range = (32'(eidx_ff) < 32'(MAX_ENTRIES));
   assign idx_wide    = AW'(idx_ff);

   assign cur_mods = rd_data_ff[hmt_pkg::ENTRY_W-1:hmt_pkg::KEY_W];
   assign cur_key  = rd_data_ff[hmt_pkg::KEY_W-1:0];

   // Slot comparison
   assign is_down = (opcode_ff == hmt_pkg::OP_KEY_DOWN);
   assign is_up   = (opcode_ff == hmt_pkg::OP_KEY_UP);
   assign hit     = is_down && cur_mods[hmt_pkg::MASK_WIN] && (cur_key == key_ff) &&
                    (cur_mods == held_ff);
   assign up_clear =
      (cur_key == key_ff) ||
      (cur_mods[hmt_pkg::MASK_CTRL] &&
         ((key_ff == hmt_pkg::KC_CTRL_L) || (key_ff == hmt_pkg::KC_CTRL_R))) ||
      (cur_mods[hmt_pkg::MASK_ALT] &&
         ((key_ff == hmt_pkg::KC_ALT_L) || (key_ff == hmt_pkg::KC_ALT_R))) ||
      (cur_mods[hmt_pkg::MASK_SHIFT] &&
         ((key_ff == hmt_pkg::KC_SHIFT_L) || (key_ff == hmt_pkg::KC_SHIFT_R)));
   assign win_release = is_up && !injected_ff &&
                        ((key_ff == hmt_pkg::KC_WIN_L) || (key_ff == hmt_pkg::KC_WIN_R));

   // Status to controller
   assign status.opcode   = opcode_ff;
   assign status.injected = injected_ff;
   assign status.empty    = (live_n == '0);
   assign status.last     = ((LC_W'(idx_ff) + LC_W'(1)) == live_n);
   assign status.hit      = hit;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Capture of the request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff   <= hmt_pkg::OP_NOP;
         injected_ff <= 1'b0;
      end else if (cmd.capture) begin
         opcode_ff   <= hmt_pkg::opcode_type'(req_opcode);
         injected_ff <= req_injected;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         eidx_ff  <= req_entry_index;
         emods_ff <= req_entry_mods;
         ekey_ff  <= req_entry_key;
         key_ff   <= req_key_code;
         held_ff  <= req_modifiers_held;
      end
   end

   // Slot counter and prefetch address: the next slot is read while this one is checked
   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.scan_step) begin
         idx_in = IDX_W'(idx_ff + 1'b1);
      end
      rd_addr = cmd.scan_start ? '0 : IDX_W'(idx_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_write && ld_in_range) begin
         entry_mem[ld_addr] <= {emods_ff, ekey_ff};
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // Active flags
   always_comb begin
      active_in = active_ff;
      if (cmd.load_write && ld_in_range) begin
         active_in[ld_addr] = 1'b0;
      end
      if (cmd.scan_step) begin
         if (hit) begin
            active_in[idx_ff] = 1'b1;
         end else if (is_up && up_clear) begin
            active_in[idx_ff] = 1'b0;
         end
      end
      if (cmd.result_load && win_release) begin
         active_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   // Result accumulation
   always_comb begin
      fire_in = fire_ff;
      fidx_in = fidx_ff;
      supp_in = supp_ff;
      if (cmd.capture) begin
         fire_in = 1'b0;
         fidx_in = '0;
         supp_in = 1'b0;
      end else if (cmd.scan_step && hit) begin
         supp_in = 1'b1;
         if (!active_ff[idx_ff]) begin
            fire_in = 1'b1;
            fidx_in = idx_wide[hmt_pkg::SLOT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      fire_ff <= fire_in;
      fidx_ff <= fidx_in;
      supp_ff <= supp_in;
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_fire_ff <= fire_ff;
         rsp_fidx_ff <= fidx_ff;
         rsp_supp_ff <= supp_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fire       = rsp_fire_ff;
   assign rsp_fire_index = rsp_fidx_ff;
   assign rsp_suppress   = rsp_supp_ff;

endmodule

`default_nettype wire

FILE: design/hotkey_match_table.sv
// Hotkey match table: top level with register file, controller and datapath.
//
// Request channel (req_*): one transaction per load, key-down, key-up or no-op.
// Response channel (rsp_*): exactly one result per request, in order.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. Register entry_count sits at byte address 0 of the APB port.
//
// One request at a time. Loads, no-ops, injected events and events with no
// live slots go from decode straight to the finish step, which loads the result.
// Key events walk the live slots in order, one slot per cycle through the
// registered read port of the slot memory, visiting at most the live count (a
// key-down stops at its first match). A new request is taken once the result has
// gone to the output register, even while that result is still stalled.
// When rsp_stall holds the output register full, the next finished result waits
// in the datapath and the request side stays stalled.
// Reset (synchronous) clears all active flags, entry_count and both channels.
// Slot contents are undefined until loaded; no clearing pass is run.
`default_nettype none

module hotkey_match_table #(
   parameter int unsigned MAX_ENTRIES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_opcode,
   input  wire logic [hmt_pkg::SLOT_W-1:0]          req_entry_index,
   input  wire logic [hmt_pkg::MODS_W-1:0]          req_entry_mods,
   input  wire logic [hmt_pkg::KEY_W-1:0]           req_entry_key,
   input  wire logic [hmt_pkg::KEY_W-1:0]           req_key_code,
   input  wire logic [hmt_pkg::MODS_W-1:0]          req_modifiers_held,
   input  wire logic                                req_injected,
   // Response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_fire,
   output logic [hmt_pkg::SLOT_W-1:0]               rsp_fire_index,
   output logic                                     rsp_suppress,
   // Register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [hmt_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [hmt_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [hmt_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                     pready
);

   logic [hmt_pkg::COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic                        csr_write;
   hmt_pkg::cmd_type            cmd;
   hmt_pkg::status_type         status;

   // Register file
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == hmt_pkg::REG_ENTRY_COUNT);

   assign entry_count_in = csr_write ? pwdata[hmt_pkg::COUNT_W-1:0] : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == hmt_pkg::REG_ENTRY_COUNT) begin
         prdata = hmt_pkg::CSR_DATA_W'(entry_count_ff);
      end
   end

   // Controller
   hmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   hmt_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .entry_count        (entry_count_ff),
      .req_opcode         (req_opcode),
      .req_entry_index    (req_entry_index),
      .req_entry_mods     (req_entry_mods),
      .req_entry_key      (req_entry_key),
      .req_key_code       (req_key_code),
      .req_modifiers_held (req_modifiers_held),
      .req_injected       (req_injected),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fire           (rsp_fire),
      .rsp_fire_index     (rsp_fire_index),
      .rsp_suppress       (rsp_suppress)
   );

   // An accepted request keeps the block busy for the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not busy after accepting a transaction");

   // A new result only appears while a request is in progress
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result produced with no request in progress");

   // A firing hotkey always swallows its event
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fire) |-> rsp_suppress)
      else $error("fire without suppress");

   // Result loads only come from the finish step, never with a fresh capture
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.result_load && cmd.capture))
      else $error("result load and capture in the same cycle");

endmodule

`default_nettype wire
